// ===== rtl/pcg_pkg.sv =====
// Package for the pulse and chirp generator: command and mode codes, sizes,
// amplitude limits, sweep constants and the quarter-wave sine table.
// No dependencies.
package pcg_pkg;

    localparam int CHIRP_LEN      = 4000;
    localparam int PULSE_LEN      = 20;
    localparam int SINE_ADDR_BITS = 10;

    localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
    localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
    localparam int PULSE_W      = $clog2(PULSE_LEN + 1);
    localparam int TICK_W       = $clog2(CHIRP_LEN + 1);
    localparam int AMP_W        = 10;
    localparam int SINE_W       = 15;
    localparam int DRIVE_W      = 11;
    localparam int REQ_W        = 16;
    localparam int CMD_W        = 3;

    localparam logic [AMP_W-1:0] AMP_CAP       = AMP_W'(900);
    localparam logic [AMP_W-1:0] KICK_DEFAULT  = AMP_W'(600);
    localparam logic [AMP_W-1:0] CHIRP_DEFAULT = AMP_W'(300);

    localparam logic [31:0] CHIRP_STEP0 = 32'd10737418;
    localparam logic [63:0] CHIRP_DELTA_W =
        ((64'd49 << 32) + 64'd200 * CHIRP_LEN) / (64'd400 * CHIRP_LEN);
    localparam logic [31:0] CHIRP_DELTA = CHIRP_DELTA_W[31:0];

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_KICK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHIRP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FALL  = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_CHIRP = 2'd2
    } t_mode;

    typedef logic [SINE_W-1:0] t_sine_rom [QUARTER_SIZE];

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [SINE_W-1:0] sine_entry(input int k);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        a  = (64'(k) * HALF_PI_Q30) >> QUARTER_BITS;
        a2 = (a * a) >> 30;
        t  = Q30_ONE - a2 / 110;
        t  = Q30_ONE - ((a2 * t) >> 30) / 72;
        t  = Q30_ONE - ((a2 * t) >> 30) / 42;
        t  = Q30_ONE - ((a2 * t) >> 30) / 20;
        t  = Q30_ONE - ((a2 * t) >> 30) / 6;
        s  = (a * t) >> 30;
        s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SINE_W-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k < QUARTER_SIZE; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom         SINE_ROM  = build_sine_rom();
    localparam logic [SINE_W-1:0] SINE_PEAK = sine_entry(QUARTER_SIZE);

endpackage

// ===== rtl/pulse_and_chirp_generator.sv =====
// Pulse and chirp disturbance generator, top level.
// Depends on pcg_pkg for codes, sizes and the sine table.
//
// Usage: one input transfer per control tick carries i_cmd and
// i_amp_request (tick, start pulse, start chirp, stop, fall). Each input
// transfer yields exactly one output transfer with o_drive, the value to
// inject for this tick (zero on non-tick commands), and o_active, high while
// a pulse or chirp is still running.
// Each item passes the input register and then the result register before
// o_valid rises for it. Throughput: one item per cycle while i_stall is low;
// the limit is the phase accumulator update, sine table read and amplitude
// multiply that sit between the input register and the result register.
// Stall: while i_stall holds a result, o_drive and o_active stay fixed; the
// input register still takes one more item, then o_stall rises until the
// result is transferred.
// Reset (i_rst_n low, synchronous): both registers empty, mode idle, phase
// zero and phase increment at the 0.5 Hz start value.
module pulse_and_chirp_generator
    import pcg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic signed [REQ_W-1:0]   i_amp_request,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic                      o_active
);

    logic                    r_s1_valid;
    logic [CMD_W-1:0]        r_s1_cmd;
    logic [REQ_W-1:0]        r_s1_amp;
    logic                    r_out_valid;
    logic [DRIVE_W-1:0]      r_drive;
    logic                    r_active;

    t_mode                   r_mode,       n_mode;
    logic [AMP_W-1:0]        r_amp,        n_amp;
    logic [PULSE_W-1:0]      r_pulse_left, n_pulse_left;
    logic [TICK_W-1:0]       r_tick,       n_tick;
    logic [31:0]             r_phase,      n_phase;
    logic [31:0]             r_step,       n_step;
    logic [DRIVE_W-1:0]      n_drive;

    logic                    w_advance;
    logic                    w_accept;
    logic                    w_req_pos;
    logic                    w_req_over;
    logic [AMP_W-1:0]        w_kick_amp;
    logic [AMP_W-1:0]        w_chirp_amp;
    logic [31:0]             w_phase_sum;
    logic [QUARTER_BITS-1:0] w_r;
    logic [1:0]              w_quad;
    logic [QUARTER_BITS-1:0] w_idx;
    logic [SINE_W-1:0]       w_sine;
    logic [AMP_W+SINE_W-1:0] w_prod;
    logic [DRIVE_W-1:0]      w_mag;
    logic [DRIVE_W-1:0]      w_sine_drive;

    assign w_advance = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    assign o_valid  = r_out_valid;
    assign o_drive  = r_drive;
    assign o_active = r_active;

    // amplitude selection
    assign w_req_pos   = !r_s1_amp[REQ_W-1] && (r_s1_amp != '0);
    assign w_req_over  = $signed(r_s1_amp) > $signed({{(REQ_W-AMP_W){1'b0}}, AMP_CAP});
    assign w_kick_amp  = !w_req_pos ? KICK_DEFAULT :
                         (w_req_over ? AMP_CAP : r_s1_amp[AMP_W-1:0]);
    assign w_chirp_amp = !w_req_pos ? CHIRP_DEFAULT :
                         (w_req_over ? AMP_CAP : r_s1_amp[AMP_W-1:0]);

    // sine lookup on the advanced phase
    assign w_phase_sum  = r_phase + r_step;
    assign w_quad       = w_phase_sum[31 -: 2];
    assign w_r          = w_phase_sum[29 -: QUARTER_BITS];
    assign w_idx        = w_quad[0] ? (QUARTER_BITS'(0) - w_r) : w_r;
    assign w_sine       = (w_quad[0] && (w_r == '0)) ? SINE_PEAK : SINE_ROM[w_idx];
    assign w_prod       = (AMP_W+SINE_W)'(r_amp) * (AMP_W+SINE_W)'(w_sine);
    assign w_mag        = {1'b0, w_prod[AMP_W+SINE_W-1 -: AMP_W]};
    assign w_sine_drive = w_quad[1] ? (DRIVE_W'(0) - w_mag) : w_mag;

    always_comb begin
        n_mode       = r_mode;
        n_amp        = r_amp;
        n_pulse_left = r_pulse_left;
        n_tick       = r_tick;
        n_phase      = r_phase;
        n_step       = r_step;
        case (r_s1_cmd)
            CMD_TICK: begin
                case (r_mode)
                    MODE_PULSE: begin
                        if (r_pulse_left != '0) begin
                            n_pulse_left = r_pulse_left - 1'b1;
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_CHIRP: begin
                        if (r_tick < TICK_W'(CHIRP_LEN)) begin
                            n_phase = w_phase_sum;
                            n_step  = r_step + CHIRP_DELTA;
                            n_tick  = r_tick + 1'b1;
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_KICK: begin
                n_amp        = w_kick_amp;
                n_pulse_left = PULSE_W'(PULSE_LEN);
                n_mode       = MODE_PULSE;
            end
            CMD_CHIRP: begin
                n_amp   = w_chirp_amp;
                n_tick  = '0;
                n_phase = '0;
                n_step  = CHIRP_STEP0;
                n_mode  = MODE_CHIRP;
            end
            CMD_STOP, CMD_FALL: begin
                n_mode = MODE_IDLE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_drive = '0;
        if (r_s1_cmd == CMD_TICK) begin
            case (r_mode)
                MODE_PULSE: begin
                    if (r_pulse_left != '0) begin
                        n_drive = DRIVE_W'(r_amp);
                    end
                end
                MODE_CHIRP: begin
                    if (r_tick < TICK_W'(CHIRP_LEN)) begin
                        n_drive = w_sine_drive;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= MODE_IDLE;
            r_amp        <= '0;
            r_pulse_left <= '0;
            r_tick       <= '0;
            r_phase      <= '0;
            r_step       <= CHIRP_STEP0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (r_s1_valid && w_advance) begin
                r_mode       <= n_mode;
                r_amp        <= n_amp;
                r_pulse_left <= n_pulse_left;
                r_tick       <= n_tick;
                r_phase      <= n_phase;
                r_step       <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd <= i_cmd;
            r_s1_amp <= i_amp_request;
        end
        if (r_s1_valid && w_advance) begin
            r_drive  <= n_drive;
            r_active <= (n_mode != MODE_IDLE);
        end
    end

`ifndef SYNTH
    a_drive_implies_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_drive != '0)) |-> r_active)
        else $error("nonzero drive with no disturbance running");

    a_pulse_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PULSE) |-> (r_pulse_left <= PULSE_W'(PULSE_LEN)))
        else $error("pulse counter out of range");

    a_chirp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_CHIRP) |-> (r_tick <= TICK_W'(CHIRP_LEN)))
        else $error("chirp tick counter out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_drive) && $stable(r_active)))
        else $error("stalled result changed or dropped");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with room available");
`endif

endmodule

// ===== verif/tb_pulse_and_chirp_generator.sv =====
// Testbench for pulse_and_chirp_generator: directed and random command streams
// checked item by item against a built-in model of the disturbance generator.
// Depends on pcg_pkg for command codes, modes and sizes.
`timescale 1ns / 1ps

module tb_pulse_and_chirp_generator;
    import pcg_pkg::*;

    localparam int          QTR_BITS     = SINE_ADDR_BITS - 2;
    localparam int          QTR_SIZE     = 1 << QTR_BITS;
    localparam int          AMP_MAX      = 900;
    localparam int          KICK_LEVEL   = 600;
    localparam int          SWEEP_LEVEL  = 300;
    localparam bit [31:0]   STEP_START   = 32'd10737418;
    localparam bit [31:0]   SWEEP_DELTA  =
        32'(((64'd49 << 32) + 64'd200 * CHIRP_LEN) / (64'd400 * CHIRP_LEN));
    localparam longint unsigned UNIT_Q30         = 64'd1 << 30;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int          RANDOM_ITEMS = 1200;
    localparam int          STREAM_TICKS = 300;

    class disturbance_tracker;
        typedef struct packed {
            logic signed [DRIVE_W-1:0] drive;
            logic                      active;
        } t_expect;

        t_expect          pending_out[$];
        bit [14:0]        sine_mag [QTR_SIZE + 1];
        t_mode            mode;
        int unsigned      amp;
        int unsigned      pulse_left;
        int unsigned      chirp_tick;
        bit [31:0]        phase;
        bit [31:0]        phase_step;
        int               miss_count;
        int               n_items;
        int               n_kicks;
        int               n_chirps;
        int               n_runouts;

        function new();
            for (int k = 0; k <= QTR_SIZE; k++) begin
                sine_mag[k] = quarter_sine(k);
            end
            mode       = MODE_IDLE;
            amp        = 0;
            pulse_left = 0;
            chirp_tick = 0;
            phase      = 0;
            phase_step = STEP_START;
        endfunction

        function bit [14:0] quarter_sine(int unsigned k);
            longint unsigned a;
            longint unsigned a2;
            longint unsigned t;
            longint unsigned s;
            a  = (64'(k) * QUARTER_TURN_Q30) >> QTR_BITS;
            a2 = (a * a) >> 30;
            t  = UNIT_Q30 - a2 / 64'd110;
            t  = UNIT_Q30 - ((a2 * t) >> 30) / 64'd72;
            t  = UNIT_Q30 - ((a2 * t) >> 30) / 64'd42;
            t  = UNIT_Q30 - ((a2 * t) >> 30) / 64'd20;
            t  = UNIT_Q30 - ((a2 * t) >> 30) / 64'd6;
            s  = (a * t) >> 30;
            s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            return s[14:0];
        endfunction

        function int unsigned clamp_amp(logic signed [REQ_W-1:0] req, int unsigned dflt);
            if (req <= 0) begin
                return dflt;
            end
            if (req > AMP_MAX) begin
                return AMP_MAX;
            end
            return int'(req);
        endfunction

        function int sweep_level();
            int unsigned addr;
            int unsigned quad;
            int unsigned r;
            int unsigned k;
            int          mag;
            addr = phase >> (32 - SINE_ADDR_BITS);
            quad = (addr >> QTR_BITS) & 3;
            r    = addr & (QTR_SIZE - 1);
            k    = quad[0] ? QTR_SIZE - r : r;
            mag  = int'((amp * sine_mag[k]) >> 15);
            return quad[1] ? -mag : mag;
        endfunction

        function void take_command(logic [CMD_W-1:0] cmd, logic signed [REQ_W-1:0] req);
            t_expect e;
            int      level;
            level = 0;
            n_items++;
            case (cmd)
                CMD_TICK: begin
                    if (mode == MODE_PULSE) begin
                        if (pulse_left > 0) begin
                            pulse_left--;
                            level = int'(amp);
                        end else begin
                            mode = MODE_IDLE;
                            n_runouts++;
                        end
                    end else if (mode == MODE_CHIRP) begin
                        if (chirp_tick < CHIRP_LEN) begin
                            phase      = phase + phase_step;
                            level      = sweep_level();
                            phase_step = phase_step + SWEEP_DELTA;
                            chirp_tick++;
                        end else begin
                            mode = MODE_IDLE;
                            n_runouts++;
                        end
                    end
                end
                CMD_KICK: begin
                    amp        = clamp_amp(req, KICK_LEVEL);
                    pulse_left = PULSE_LEN;
                    mode       = MODE_PULSE;
                    n_kicks++;
                end
                CMD_CHIRP: begin
                    amp        = clamp_amp(req, SWEEP_LEVEL);
                    chirp_tick = 0;
                    phase      = 0;
                    phase_step = STEP_START;
                    mode       = MODE_CHIRP;
                    n_chirps++;
                end
                CMD_STOP, CMD_FALL: begin
                    mode = MODE_IDLE;
                end
                default: ;
            endcase
            e.drive  = DRIVE_W'(level);
            e.active = (mode != MODE_IDLE);
            pending_out.push_back(e);
        endfunction

        task report_miss(string msg);
            miss_count++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_output(logic signed [DRIVE_W-1:0] drive, logic active);
            t_expect e;
            if (pending_out.size() == 0) begin
                report_miss($sformatf("unexpected result drive %0d active %0b",
                                      drive, active));
                return;
            end
            e = pending_out.pop_front();
            if (drive !== e.drive) begin
                report_miss($sformatf("drive %0d, wanted %0d", drive, e.drive));
            end
            if (active !== e.active) begin
                report_miss($sformatf("active %0b, wanted %0b", active, e.active));
            end
        endtask
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic [CMD_W-1:0]          i_cmd         = CMD_TICK;
    logic signed [REQ_W-1:0]   i_amp_request = '0;
    logic                      i_stall       = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [DRIVE_W-1:0] o_drive;
    logic                      o_active;

    disturbance_tracker tracker;
    int                 send_idle_pct = 21;
    int                 recv_stall_pct = 21;

    pulse_and_chirp_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_amp_request (i_amp_request),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive       (o_drive),
        .o_active      (o_active)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_output(o_drive, o_active);
        end
    end

    function automatic logic signed [REQ_W-1:0] rand_request();
        case ($urandom_range(3))
            0: return REQ_W'($urandom);
            1: return REQ_W'($urandom_range(1, AMP_MAX));
            2: return REQ_W'($urandom_range(AMP_MAX - 50, AMP_MAX + 50));
            default: return REQ_W'(-int'($urandom_range(2)));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic issue_command(logic [CMD_W-1:0] cmd, logic signed [REQ_W-1:0] req);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_amp_request <= req;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        tracker.take_command(cmd, req);
        @(negedge i_clk);
    endtask

    task automatic issue_ticks(int count);
        for (int n = 0; n < count; n++) begin
            issue_command(CMD_TICK, rand_request());
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (tracker.pending_out.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int pick;
        tracker = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue_command(CMD_TICK, 16'sd0);
        issue_command(CMD_STOP, 16'sd5);
        issue_command(CMD_FALL, -16'sd5);
        issue_command(CMD_W'(5), 16'sh7fff);
        issue_command(CMD_KICK, 16'sd0);
        issue_ticks(2);
        issue_command(CMD_W'(6), 16'sh8000);
        issue_command(CMD_KICK, 16'sh8000);
        issue_ticks(1);
        issue_command(CMD_KICK, 16'sh7fff);
        issue_ticks(1);
        issue_command(CMD_KICK, 16'sd901);
        issue_command(CMD_KICK, 16'sd1);
        issue_ticks(1);
        issue_command(CMD_CHIRP, 16'sd0);
        issue_ticks(2);
        issue_command(CMD_W'(7), -16'sd1);
        issue_command(CMD_CHIRP, -16'sd1);
        issue_ticks(1);
        issue_command(CMD_CHIRP, 16'sh7fff);
        issue_ticks(2);
        issue_command(CMD_STOP, 16'sd0);
        issue_ticks(1);
        issue_command(CMD_KICK, 16'sd900);
        issue_command(CMD_FALL, 16'sd0);
        issue_ticks(1);

        // run part of one sweep with both sides streaming
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        issue_command(CMD_CHIRP, 16'sd900);
        issue_ticks(STREAM_TICKS);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        drain_results();
        @(negedge i_clk);

        while (tracker.n_items < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                issue_command(CMD_KICK, rand_request());
                issue_ticks($urandom_range(PULSE_LEN + 4));
            end else if (pick < 70) begin
                issue_command(CMD_CHIRP, rand_request());
                issue_ticks($urandom_range(1, 60));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    issue_command(CMD_W'($urandom_range(7)), REQ_W'($urandom));
                end
            end
            if ($urandom_range(9) < 2) begin
                issue_command($urandom_range(1) ? CMD_STOP : CMD_FALL, rand_request());
            end
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        $display("covered %0d transfers: %0d pulse and %0d sweep starts, %0d run to their end",
                 tracker.n_items, tracker.n_kicks, tracker.n_chirps, tracker.n_runouts);
        $display("saw %0d mismatches", tracker.miss_count);
        if (tracker.miss_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", tracker.pending_out.size());
        $display("tb: failure");
        $finish;
    end

endmodule
